/* hdl/text_console_writer_assert.svh */
// ----------------------------------------------------------------------------
// text_console_writer assertion macros
// Implication checks on the console clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text_console_writer: same-cycle check failed");
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("text_console_writer: next-cycle check failed");
`else
`define TCW_ASSERT_NOW(lbl, ante, cons)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/txcw_pkg.sv */
// ----------------------------------------------------------------------------
// txcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package txcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int CELL_W = 16;
    localparam int CHR_W  = 8;
    localparam int ADR_IN_W = 11;
    // wide enough for row * columns + column at the largest geometry
    localparam int PROD_W = 13;

    localparam logic [CHR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHR_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        OP_STREAM = 2'd0,
        OP_PUT    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,    // zero the store after reset
        ST_IDLE,
        ST_READ,    // wait for registered read data
        ST_SCROLL,  // copy each row one row up
        ST_DRAIN,   // last pending copy write
        ST_BLANK,   // fill bottom row with spaces
        ST_FILL     // clear screen
    } t_state;

endpackage

/* hdl/txcw_ram.sv */
// ----------------------------------------------------------------------------
// txcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module txcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, cursor, stream/put/clear/read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result is loaded
// into the o_ ports, flagged by o_strobe high for a single cycle, and cannot be
// stalled. Stream commands that do not scroll, put commands and reads outside
// the store finish in the accept cycle, with the result in the cycle after. A
// read inside the store passes through ST_READ for the registered RAM read. A
// scroll walks the store through the one RAM port pair: ST_SCROLL and ST_DRAIN
// copy each row one row up, then ST_BLANK fills the bottom row with spaces.
// Clear screen fills every cell with spaces in ST_FILL. After reset the store
// is zeroed one cell per cycle; busy stays high until every cell is written.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [txcw_pkg::CHR_W-1:0]     i_character,
    input  logic [txcw_pkg::CHR_W-1:0]     i_color,
    input  logic [7:0]                     i_column,
    input  logic [7:0]                     i_row,
    input  logic [txcw_pkg::ADR_IN_W-1:0]  i_cell_address,
    output logic                           o_strobe,
    output logic [txcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic [txcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [txcw_pkg::LIN_W-1:0]     o_cursor_linear,
    output logic [txcw_pkg::CELL_W-1:0]    o_read_data
);

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int AW          = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW          = (AW > txcw_pkg::ADR_IN_W) ? AW : txcw_pkg::ADR_IN_W;
    localparam int COPY_LAST   = CELLS - COLUMNS - 1;
    localparam int BLANK_FIRST = CELLS - COLUMNS;

    localparam logic [AW-1:0] IDX_LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] IDX_COPY   = AW'(COPY_LAST);
    localparam logic [AW-1:0] IDX_BLANK  = AW'(BLANK_FIRST);
    localparam logic [AW-1:0] IDX_COLS   = AW'(COLUMNS);
    localparam logic [AW-1:0] IDX_ONE    = AW'(1);

    txcw_pkg::t_state r_state, n_state;

    logic [txcw_pkg::COL_W-1:0]  r_cur_col, n_cur_col;
    logic [txcw_pkg::ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [AW-1:0]               r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [AW-1:0]               r_waddr, n_waddr;
    logic [txcw_pkg::CHR_W-1:0]  r_color, n_color;

    logic                        r_strobe;
    logic [txcw_pkg::COL_W-1:0]  r_o_col;
    logic [txcw_pkg::ROW_W-1:0]  r_o_row;
    logic [txcw_pkg::LIN_W-1:0]  r_o_lin;
    logic [txcw_pkg::CELL_W-1:0] r_o_rd;

    logic                        w_load;
    logic [txcw_pkg::CELL_W-1:0] w_rd_val;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [txcw_pkg::CELL_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [txcw_pkg::CELL_W-1:0] mem_rdata;

    // decode of the incoming command
    logic                        w_accept;
    txcw_pkg::t_op               w_op;
    logic                        w_is_nl;
    logic [7:0]                  w_col_inc;
    logic                        w_end_line;
    logic [5:0]                  w_row_inc;
    logic                        w_scroll;
    logic                        w_put_ok;
    logic                        w_rd_ok;
    logic [XW-1:0]               w_rd_ext;
    logic [txcw_pkg::COL_W-1:0]  w_m_col;
    logic [txcw_pkg::ROW_W-1:0]  w_m_row;
    logic [txcw_pkg::PROD_W-1:0] w_m_lin;
    logic [txcw_pkg::PROD_W-1:0] w_o_lin;

    assign busy       = (r_state != txcw_pkg::ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_op       = txcw_pkg::t_op'(i_operation);
    assign w_is_nl    = (i_character == txcw_pkg::CHAR_NEWLINE);
    assign w_col_inc  = 8'(r_cur_col) + 8'd1;
    assign w_end_line = w_is_nl || (w_col_inc == 8'(COLUMNS));
    assign w_row_inc  = 6'(r_cur_row) + 6'd1;
    assign w_scroll   = w_end_line && (w_row_inc == 6'(ROWS));
    assign w_put_ok   = (i_column < 8'(COLUMNS)) && (i_row < 8'(ROWS));
    assign w_rd_ok    = (32'(i_cell_address) < 32'(CELLS));
    assign w_rd_ext   = XW'(i_cell_address);

    // one multiply-add serves the stream cursor and the put target
    assign w_m_col = (w_op == txcw_pkg::OP_PUT) ? i_column[txcw_pkg::COL_W-1:0] : r_cur_col;
    assign w_m_row = (w_op == txcw_pkg::OP_PUT) ? i_row[txcw_pkg::ROW_W-1:0] : r_cur_row;
    assign w_m_lin = txcw_pkg::PROD_W'(w_m_row) * txcw_pkg::PROD_W'(COLUMNS)
                   + txcw_pkg::PROD_W'(w_m_col);
    assign w_o_lin = txcw_pkg::PROD_W'(n_cur_row) * txcw_pkg::PROD_W'(COLUMNS)
                   + txcw_pkg::PROD_W'(n_cur_col);

    txcw_ram #(
        .WIDTH (txcw_pkg::CELL_W),
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            txcw_pkg::ST_INIT: begin
                if (r_idx == IDX_LAST) n_state = txcw_pkg::ST_IDLE;
            end
            txcw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        txcw_pkg::OP_STREAM: begin
                            if (w_scroll) begin
                                n_state = (ROWS > 1) ? txcw_pkg::ST_SCROLL
                                                     : txcw_pkg::ST_BLANK;
                            end
                        end
                        txcw_pkg::OP_CLEAR: n_state = txcw_pkg::ST_FILL;
                        txcw_pkg::OP_READ: begin
                            if (w_rd_ok) n_state = txcw_pkg::ST_READ;
                        end
                        default: n_state = txcw_pkg::ST_IDLE;
                    endcase
                end
            end
            txcw_pkg::ST_READ:   n_state = txcw_pkg::ST_IDLE;
            txcw_pkg::ST_SCROLL: begin
                if (r_idx == IDX_COPY) n_state = txcw_pkg::ST_DRAIN;
            end
            txcw_pkg::ST_DRAIN:  n_state = txcw_pkg::ST_BLANK;
            txcw_pkg::ST_BLANK,
            txcw_pkg::ST_FILL: begin
                if (r_idx == IDX_LAST) n_state = txcw_pkg::ST_IDLE;
            end
            default: n_state = txcw_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_waddr   = r_waddr;
        n_color   = r_color;
        w_load    = 1'b0;
        w_rd_val  = '0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {r_color, txcw_pkg::CHAR_SPACE};
        mem_raddr = w_rd_ext[AW-1:0];
        case (r_state)
            txcw_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_idx     = r_idx + IDX_ONE;
            end
            txcw_pkg::ST_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (w_accept) begin
                    n_color = i_color;
                    case (w_op)
                        txcw_pkg::OP_STREAM: begin
                            if (!w_is_nl) begin
                                mem_we    = 1'b1;
                                mem_waddr = w_m_lin[AW-1:0];
                                mem_wdata = {i_color, i_character};
                            end
                            if (w_end_line) begin
                                n_cur_col = '0;
                                n_cur_row = w_row_inc[txcw_pkg::ROW_W-1:0];
                            end else begin
                                n_cur_col = w_col_inc[txcw_pkg::COL_W-1:0];
                            end
                            if (w_scroll) begin
                                n_cur_col = '0;
                                n_cur_row = txcw_pkg::ROW_W'(ROWS - 1);
                                if (ROWS == 1) n_idx = IDX_BLANK;
                            end else begin
                                w_load = 1'b1;
                            end
                        end
                        txcw_pkg::OP_PUT: begin
                            w_load = 1'b1;
                            if (w_put_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = w_m_lin[AW-1:0];
                                mem_wdata = {i_color, i_character};
                                n_cur_col = i_column[txcw_pkg::COL_W-1:0];
                                n_cur_row = i_row[txcw_pkg::ROW_W-1:0];
                            end
                        end
                        txcw_pkg::OP_CLEAR: begin
                            n_cur_col = '0;
                            n_cur_row = '0;
                        end
                        default: begin
                            // out-of-range read answers zero at once
                            if (!w_rd_ok) w_load = 1'b1;
                        end
                    endcase
                end
            end
            txcw_pkg::ST_READ: begin
                w_load   = 1'b1;
                w_rd_val = mem_rdata;
            end
            txcw_pkg::ST_SCROLL: begin
                // read one row below, write the word read last cycle
                mem_raddr = r_idx + IDX_COLS;
                mem_we    = r_pend;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
                n_pend    = 1'b1;
                n_waddr   = r_idx;
                n_idx     = r_idx + IDX_ONE;
            end
            txcw_pkg::ST_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
                n_pend    = 1'b0;
                n_idx     = IDX_BLANK;
            end
            txcw_pkg::ST_BLANK,
            txcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                n_idx  = r_idx + IDX_ONE;
                if (r_idx == IDX_LAST) w_load = 1'b1;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= txcw_pkg::ST_INIT;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_strobe  <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_color <= n_color;
        if (w_load) begin
            r_o_col <= n_cur_col;
            r_o_row <= n_cur_row;
            r_o_lin <= w_o_lin[txcw_pkg::LIN_W-1:0];
            r_o_rd  <= w_rd_val;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_cursor_col    = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_linear = r_o_lin;
    assign o_read_data     = r_o_rd;

`include "text_console_writer_assert.svh"

    `TCW_ASSERT_NOW(a_init_quiet, r_state == txcw_pkg::ST_INIT, !o_strobe && busy)
    `TCW_ASSERT_NEXT(a_read_answers, r_state == txcw_pkg::ST_READ, o_strobe)
    `TCW_ASSERT_NEXT(a_clear_holds,
        w_accept && (w_op == txcw_pkg::OP_CLEAR), busy && !o_strobe)
    `TCW_ASSERT_NOW(a_cursor_range, o_strobe,
        (32'(o_cursor_col) < 32'(COLUMNS)) && (32'(o_cursor_row) < 32'(ROWS)))

endmodule
